FILE: hdl/iprs_pkg.sv
// Shared constants, types and helpers for the IPv4 range index search block.
package iprs_pkg;

   localparam int DB_BYTES_DEFAULT = 1048576;
   localparam int REG_W            = 24;
   localparam int ADDR_W           = 25;
   localparam int IDX_W            = 22;
   localparam int IP_W             = 32;
   localparam int PTR_W            = 24;
   localparam int REQ_DATA_W       = 64;
   localparam int RSP_DATA_W       = 24;
   localparam int CSR_INDEX_W      = 1;

   localparam logic [3:0]      REC_SIZE = 4'd7;
   localparam logic [IP_W-1:0] TOP_MASK = 32'hffffff00;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_BEGIN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_END   = 1'b1;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [2:0] NBYTES_START = 3'd4;
   localparam logic [2:0] NBYTES_PTR   = 3'd3;
   localparam logic [2:0] NBYTES_END   = 3'd4;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        nbytes;
   } fetch_req_type;

   typedef struct packed {
      logic            done;
      logic [IP_W-1:0] word;
   } fetch_rsp_type;

   // byte offset of index record k: begin + 7k
   function automatic logic [ADDR_W-1:0] rec_addr(input logic [REG_W-1:0] base,
                                                  input logic [IDX_W-1:0] k);
      logic [ADDR_W-1:0] k7;
      k7 = ADDR_W'({k, 3'b000}) - ADDR_W'(k);
      return ADDR_W'(base) + k7;
   endfunction

endpackage

FILE: hdl/iprs_ram.sv
// Generic single-port RAM with registered read.
module iprs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/iprs_fetch.sv
// Byte-serial little-endian word fetch from the database RAM.
module iprs_fetch #(
   parameter int DB_BYTES = iprs_pkg::DB_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  iprs_pkg::fetch_req_type       fetch_req,
   output iprs_pkg::fetch_rsp_type       fetch_rsp,
   output logic [$clog2(DB_BYTES)-1:0]   mem_addr,
   input  logic [7:0]                    mem_rdata
);
   import iprs_pkg::*;

   localparam int AW = $clog2(DB_BYTES);
   localparam logic [ADDR_W-1:0] DB_LIMIT = ADDR_W'(DB_BYTES);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              oob_ff, oob_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [2:0]        n_ff, n_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [IP_W-1:0]   word_ff, word_in;
   logic [1:0]        lane;

   assign lane = cnt_ff[1:0] - 2'd1;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      oob_in  = oob_ff;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      addr_in = addr_ff;
      word_in = word_ff;
      if (fetch_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         n_in    = fetch_req.nbytes;
         addr_in = fetch_req.addr;
         word_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff < n_ff) begin
            addr_in = addr_ff + ADDR_W'(1);
            oob_in  = (addr_ff >= DB_LIMIT);
         end
         if (cnt_ff != 3'd0) begin
            word_in[8*lane +: 8] = oob_ff ? 8'd0 : mem_rdata;
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == n_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      oob_ff  <= oob_in;
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      addr_ff <= addr_in;
      word_ff <= word_in;
   end

   assign mem_addr       = addr_ff[AW-1:0];
   assign fetch_rsp.done = done_ff;
   assign fetch_rsp.word = word_ff;
endmodule

FILE: hdl/iprs_seq.sv
// Lookup sequencer: record count division, binary search and range check.
module iprs_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [iprs_pkg::IP_W-1:0]     query,
   input  logic [iprs_pkg::REG_W-1:0]    index_begin,
   input  logic [iprs_pkg::REG_W-1:0]    index_end,
   output logic                          ready,
   output iprs_pkg::fetch_req_type       fetch_req,
   input  iprs_pkg::fetch_rsp_type       fetch_rsp,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          found,
   output logic [iprs_pkg::PTR_W-1:0]    offset
);
   import iprs_pkg::*;

   // ceil(2^27 / 7): span * RECIP7 >> 27 is exactly span / 7 for any 24-bit span
   localparam int          RECIP_SHIFT = 27;
   localparam logic [24:0] RECIP7      = 25'h124924A;
   localparam int          PROD_W      = REG_W + 25;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_SEARCH, ST_PROBE, ST_START, ST_PTR, ST_END, ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [IP_W-1:0]   ip_ff, ip_in;
   logic [REG_W-1:0]  span_ff, span_in;
   logic [IDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic              stop_ff, stop_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [IP_W-1:0]   b_ff, b_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic              found_ff, found_in;
   logic [PTR_W-1:0]  offset_ff, offset_in;
   fetch_req_type     fetch_ff, fetch_in;

   logic [PROD_W-1:0] quot_prod;
   logic [IDX_W:0]    lo_plus;
   logic [IDX_W:0]    mid_sum;
   logic [IDX_W-1:0]  mid_calc;
   logic [IDX_W-1:0]  sel;
   logic              in_range;

   assign quot_prod = {25'd0, span_ff} * {{REG_W{1'b0}}, RECIP7};
   assign lo_plus   = {1'b0, lo_ff} + (IDX_W+1)'(1);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = mid_sum[IDX_W:1];
   assign sel       = ((ip_ff & TOP_MASK) == TOP_MASK) ? hi_ff : lo_ff;
   assign in_range  = (b_ff <= ip_ff) && (ip_ff <= fetch_rsp.word);

   always_comb begin
      state_in  = state_ff;
      ip_in     = ip_ff;
      span_in   = span_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      stop_in   = stop_ff;
      base_in   = base_ff;
      b_in      = b_ff;
      ptr_in    = ptr_ff;
      found_in  = found_ff;
      offset_in = offset_ff;
      fetch_in  = fetch_ff;
      fetch_in.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ip_in = query;
               if (index_end < index_begin) begin
                  found_in  = 1'b0;
                  offset_in = '0;
                  state_in  = ST_RESP;
               end else begin
                  span_in  = index_end - index_begin;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            lo_in    = '0;
            hi_in    = quot_prod[RECIP_SHIFT +: IDX_W];
            stop_in  = 1'b0;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            fetch_in.start  = 1'b1;
            fetch_in.nbytes = NBYTES_START;
            if (!stop_ff && (lo_plus < {1'b0, hi_ff})) begin
               mid_in        = mid_calc;
               fetch_in.addr = rec_addr(index_begin, mid_calc);
               state_in      = ST_PROBE;
            end else begin
               base_in       = rec_addr(index_begin, sel);
               fetch_in.addr = rec_addr(index_begin, sel);
               state_in      = ST_START;
            end
         end
         ST_PROBE: begin
            if (fetch_rsp.done) begin
               if (ip_ff == fetch_rsp.word) begin
                  lo_in   = mid_ff;
                  stop_in = 1'b1;
               end else if (ip_ff > fetch_rsp.word) begin
                  lo_in = mid_ff;
               end else begin
                  hi_in = mid_ff;
               end
               state_in = ST_SEARCH;
            end
         end
         ST_START: begin
            if (fetch_rsp.done) begin
               b_in            = fetch_rsp.word;
               fetch_in.start  = 1'b1;
               fetch_in.addr   = base_ff + ADDR_W'(4);
               fetch_in.nbytes = NBYTES_PTR;
               state_in        = ST_PTR;
            end
         end
         ST_PTR: begin
            if (fetch_rsp.done) begin
               ptr_in          = fetch_rsp.word[PTR_W-1:0];
               fetch_in.start  = 1'b1;
               fetch_in.addr   = ADDR_W'(fetch_rsp.word[PTR_W-1:0]);
               fetch_in.nbytes = NBYTES_END;
               state_in        = ST_END;
            end
         end
         ST_END: begin
            if (fetch_rsp.done) begin
               found_in  = in_range;
               offset_in = in_range ? ptr_ff : '0;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fetch_ff.start <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fetch_ff.start <= fetch_in.start;
      end
      fetch_ff.addr   <= fetch_in.addr;
      fetch_ff.nbytes <= fetch_in.nbytes;
      ip_ff     <= ip_in;
      span_ff   <= span_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      stop_ff   <= stop_in;
      base_ff   <= base_in;
      b_ff      <= b_in;
      ptr_ff    <= ptr_in;
      found_ff  <= found_in;
      offset_ff <= offset_in;
   end

   assign ready     = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign found     = found_ff;
   assign offset    = offset_ff;
   assign fetch_req = fetch_ff;
endmodule

FILE: hdl/ip_range_index_search.sv
// IPv4 range index search: database RAM, fetch unit and lookup sequencer.
//
// Requests arrive on req_*. tuser selects the kind: 0 writes one database byte
// (byte_address, byte_value), 1 looks up query_address. A byte write is taken
// only while req_tready is high; it gives no response, req_tready stays high.
// A lookup produces exactly one response on rsp_*: tuser is found, tdata the
// 24-bit record pointer (zero when not found). req_tready is low from the
// lookup's acceptance until its response is taken.
// Lookup steps: the record count (span times a reciprocal of 7) is computed first,
// then each search probe reads a 4-byte key through the single RAM port, byte by
// byte, and finally the start, pointer and end fields are fetched. The number
// of probes P is about log2 of the record count, at most 22 for the largest index.
// Reversed bounds answer in the cycle after acceptance.
// index_begin and index_end are written through csr_*, by the user only while no
// lookup runs (not enforced). Reset clears both registers and the sequencer;
// database contents are not cleared and must be loaded before use. A stalled
// response simply holds in its output register until rsp_tready rises.
module ip_range_index_search #(
   parameter int DB_BYTES = iprs_pkg::DB_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [iprs_pkg::REQ_DATA_W-1:0]    req_tdata,  // byte_address, byte_value, query_address
   input  logic                               req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [iprs_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // record_offset
   output logic                               rsp_tuser,  // found
   input  logic                               csr_we,
   input  logic [iprs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [iprs_pkg::REG_W-1:0]         csr_wdata
);
   import iprs_pkg::*;

   localparam int AW = $clog2(DB_BYTES);
   localparam logic [ADDR_W-1:0] DB_LIMIT = ADDR_W'(DB_BYTES);

   logic [REG_W-1:0] index_begin_ff, index_end_ff;
   logic [23:0]      byte_address;
   logic [7:0]       byte_value;
   logic [IP_W-1:0]  query_address;
   logic             req_accept;
   logic             load_we;
   logic             lookup_start;
   logic [AW-1:0]    fetch_addr;
   logic [AW-1:0]    ram_addr;
   logic [7:0]       ram_rdata;
   fetch_req_type    fetch_req;
   fetch_rsp_type    fetch_rsp;

   assign byte_address  = req_tdata[23:0];
   assign byte_value    = req_tdata[31:24];
   assign query_address = req_tdata[63:32];

   assign req_accept   = req_tvalid && req_tready;
   assign load_we      = req_accept && (req_tuser == MODE_LOAD) &&
                         (ADDR_W'(byte_address) < DB_LIMIT);
   assign lookup_start = req_accept && (req_tuser == MODE_LOOKUP);
   assign ram_addr     = load_we ? byte_address[AW-1:0] : fetch_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_begin_ff <= '0;
         index_end_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INDEX_BEGIN: index_begin_ff <= csr_wdata;
            CSR_INDEX_END:   index_end_ff   <= csr_wdata;
            default:         ;
         endcase
      end
   end

   iprs_ram #(
      .WIDTH (8),
      .DEPTH (DB_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (load_we),
      .addr  (ram_addr),
      .wdata (byte_value),
      .rdata (ram_rdata)
   );

   iprs_fetch #(
      .DB_BYTES (DB_BYTES)
   ) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .fetch_req (fetch_req),
      .fetch_rsp (fetch_rsp),
      .mem_addr  (fetch_addr),
      .mem_rdata (ram_rdata)
   );

   iprs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (lookup_start),
      .query       (query_address),
      .index_begin (index_begin_ff),
      .index_end   (index_end_ff),
      .ready       (req_tready),
      .fetch_req   (fetch_req),
      .fetch_rsp   (fetch_rsp),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .found       (rsp_tuser),
      .offset      (rsp_tdata)
   );

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a response is pending");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("pointer non-zero on a miss");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser == MODE_LOAD) |=> req_tready)
      else $error("byte load left the block busy");

   a_fetch_busy: assert property (@(posedge clock) disable iff (reset)
      fetch_rsp.done |-> !req_tready)
      else $error("fetch completed while idle");
`endif
endmodule
